>>> sv/xs48_pkg.sv
// ----------------------------------------------------------------------------
// xs48_pkg: shared types and constants
// Word widths, operation codes, fill words and the generator state type.
// ----------------------------------------------------------------------------
package xs48_pkg;

   localparam int WORD_W = 16;
   localparam int SEED_W = 48;
   localparam int RAND_W = 32;

   // operation codes carried in the op field
   localparam logic OP_SEED = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // fill words of the reset state; the first two also replace the seed's upper two words when both are zero
   localparam logic [WORD_W-1:0] FILL_W0 = 16'hDEAD;
   localparam logic [WORD_W-1:0] FILL_W1 = 16'hBEEF;
   localparam logic [WORD_W-1:0] FILL_W2 = 16'h0000;

   // rotate and shift amounts of one step
   localparam int ROT_OUT = 5;
   localparam int ROT_W0  = 7;
   localparam int SHL_T   = 6;
   localparam int ROT_T   = 2;

   typedef struct packed {
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
   } gen_words_type;

   localparam gen_words_type WORDS_RESET = '{w0: FILL_W0, w1: FILL_W1, w2: FILL_W2};

endpackage

>>> sv/xs48_if.sv
// ----------------------------------------------------------------------------
// xs48 channel interfaces
// Valid/ready request and response channels of the generator.
// ----------------------------------------------------------------------------
interface xs48_req_if
   import xs48_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [SEED_W-1:0] seed_value;

   modport source (output valid, output op, output seed_value, input ready);
   modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface xs48_rsp_if
   import xs48_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [RAND_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

>>> sv/xs48_step.sv
// ----------------------------------------------------------------------------
// xs48_step: one 16-bit generator step
// Output word and next state from the current three words.
// ----------------------------------------------------------------------------
module xs48_step
   import xs48_pkg::*;
(
   input  gen_words_type     words_in,
   output gen_words_type     words_out,
   output logic [WORD_W-1:0] step_word
);

   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] sum_rot;
   logic [WORD_W-1:0] t;
   logic [WORD_W-1:0] w0_rot;
   logic [WORD_W-1:0] t_shl;
   logic [WORD_W-1:0] t_rot;

   assign sum       = words_in.w0 + words_in.w2;
   assign sum_rot   = {sum[WORD_W-ROT_OUT-1:0], sum[WORD_W-1:WORD_W-ROT_OUT]};
   assign step_word = sum_rot + words_in.w0;

   assign t      = words_in.w0 ^ words_in.w2;
   assign w0_rot = {words_in.w0[WORD_W-ROT_W0-1:0], words_in.w0[WORD_W-1:WORD_W-ROT_W0]};
   assign t_shl  = {t[WORD_W-SHL_T-1:0], {SHL_T{1'b0}}};
   assign t_rot  = {t[WORD_W-ROT_T-1:0], t[WORD_W-1:WORD_W-ROT_T]};

   assign words_out.w0 = words_in.w1;
   assign words_out.w1 = w0_rot ^ t ^ t_shl;
   assign words_out.w2 = t_rot;

endmodule

>>> sv/xoroshiro48_pp_generator.sv
// ----------------------------------------------------------------------------
// xoroshiro48_pp_generator: 48-bit xoroshiro++ style random word source
// Three 16-bit state words, two chained steps per draw, one 32-bit word out.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus (sink)   : one beat per command. op = OP_SEED loads the state
//                      from seed_value and returns nothing; op = OP_DRAW
//                      returns one 32-bit random_word.
//   rsp_bus (source) : one beat per draw, in command order. Bits 31:16
//                      hold the first step's output, bits 15:0 the second.
// Path: a draw accepted into the command register passes the step chain into the result register, which drives rsp_bus.
// Throughput: one command per cycle while no draw stalls, set by the single
//   pass through two chained step units between the command register and
//   the result register; the state register updates in the same cycle.
// Stall: while the result register is full and rsp ready is low, a pending
//   draw waits in the command register and req ready drops; a pending seed
//   load proceeds since it needs no result slot.
// Reset: synchronous, active high. State returns to 0xDEAD, 0xBEEF, 0x0000;
//   command and result registers are emptied.
// Seed special case: upper two seed words both zero load 0xDEAD, 0xBEEF.
// ----------------------------------------------------------------------------
module xoroshiro48_pp_generator
   import xs48_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   xs48_req_if.sink  req_bus,
   xs48_rsp_if.source rsp_bus
);

   // command register
   logic              cmd_valid_ff, cmd_valid_in;
   logic              cmd_op_ff, cmd_op_in;
   logic [SEED_W-1:0] cmd_seed_ff, cmd_seed_in;

   // generator state
   gen_words_type     words_ff, words_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [RAND_W-1:0] out_word_ff, out_word_in;

   // step chain
   gen_words_type     mid_words;
   gen_words_type     end_words;
   logic [WORD_W-1:0] hi_word;
   logic [WORD_W-1:0] lo_word;

   // seed load words
   gen_words_type     seed_words;

   logic              req_beat;
   logic              slot_free;
   logic              cmd_done;

   xs48_step u_step_hi (
      .words_in  (words_ff),
      .words_out (mid_words),
      .step_word (hi_word)
   );

   xs48_step u_step_lo (
      .words_in  (mid_words),
      .words_out (end_words),
      .step_word (lo_word)
   );

   // seed split with the all-zero upper words fix-up
   always_comb begin
      seed_words.w0 = cmd_seed_ff[3*WORD_W-1:2*WORD_W];
      seed_words.w1 = cmd_seed_ff[2*WORD_W-1:WORD_W];
      seed_words.w2 = cmd_seed_ff[WORD_W-1:0];
      if (seed_words.w0 == '0 && seed_words.w1 == '0) begin
         seed_words.w0 = FILL_W0;
         seed_words.w1 = FILL_W1;
      end
   end

   // result slot is free when empty or draining this cycle
   assign slot_free = !out_valid_ff || rsp_bus.ready;
   // command leaves the register: seeds always, draws when a slot is free
   assign cmd_done  = cmd_valid_ff && (cmd_op_ff == OP_SEED || slot_free);

   assign req_bus.ready = !cmd_valid_ff || cmd_done;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_op_in    = cmd_op_ff;
      cmd_seed_in  = cmd_seed_ff;
      words_in     = words_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd_done) begin
         cmd_valid_in = 1'b0;
         case (cmd_op_ff)
            OP_SEED: begin
               words_in = seed_words;
            end
            OP_DRAW: begin
               words_in     = end_words;
               out_valid_in = 1'b1;
               out_word_in  = {hi_word, lo_word};
            end
            default: begin
               words_in = words_ff;
            end
         endcase
      end

      if (req_beat) begin
         cmd_valid_in = 1'b1;
         cmd_op_in    = req_bus.op;
         cmd_seed_in  = req_bus.seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         words_ff     <= WORDS_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         out_valid_ff <= out_valid_in;
         words_ff     <= words_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cmd_op_ff   <= cmd_op_in;
      cmd_seed_ff <= cmd_seed_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.random_word = out_word_ff;

endmodule

>>> sv/xs48_checker.sv
// ----------------------------------------------------------------------------
// xs48_checker: port-level checks of the generator
// Response timing and hold behavior, bound to the top level.
// ----------------------------------------------------------------------------
module xs48_checker
   import xs48_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_op,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [RAND_W-1:0] rsp_word
);

   logic req_draw;

   assign req_draw = req_valid && req_ready && (req_op == OP_DRAW);

   // stalled beat holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a fresh response needs an accepted draw before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_draw, 2))
      else $error("response without a draw");

   // a draw, then a ready sink, must give a valid response
   a_draw_latency: assert property (@(posedge clock) disable iff (reset)
      req_draw ##1 rsp_ready |=> rsp_valid)
      else $error("draw result late");

endmodule

bind xoroshiro48_pp_generator xs48_checker u_xs48_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_op    (req_bus.op),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_word  (rsp_bus.random_word)
);
